// ===== hw/rtl/tcpk_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpk_pkg
// Shared types and constants of the two-cord plotter kinematics pipeline.
// ----------------------------------------------------------------------------
package tcpk_pkg;

  // round(2*pi*2^24); one step of cord is TWO_PI_Q24*radius/(steps*2^24) mm Q.8
  localparam logic [26:0] TWO_PI_Q24 = 27'd105414357;

  // reached_y saturates once u*v reaches this value
  localparam logic [58:0] PSAT = 59'h3FFF_FF80_0001;

  localparam logic [23:0] COORD_MAX = 24'h7F_FFFF;
  localparam logic [23:0] COORD_MIN = 24'h80_0000;
  localparam logic [15:0] STEP_MAX  = 16'hFFFF;

  // result status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [1:0] REG_SPOOL_RADIUS  = 2'd1;
  localparam logic [1:0] REG_STEPS_PER_REV = 2'd2;

  // stream widths
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 80;
  localparam int unsigned OUT_USER_W = 2;

  // pipeline schedule
  localparam int unsigned LX_STEPS = 32;  // cord length root bits
  localparam int unsigned SD_STEPS = 16;  // step count quotient bits
  localparam int unsigned AL_STEPS = 35;  // quantized length quotient bits
  localparam int unsigned XQ_STEPS = 36;  // reached_x quotient bits
  localparam int unsigned RY_STEPS = 23;  // reached_y root bits

  localparam int unsigned S_SQ     = 1;
  localparam int unsigned S_RAD    = 2;
  localparam int unsigned S_SQRT0  = 3;
  localparam int unsigned S_MUL_N  = S_SQRT0 + LX_STEPS;
  localparam int unsigned S_NUM    = S_MUL_N + 1;
  localparam int unsigned S_DIV0   = S_NUM + 1;
  localparam int unsigned S_STEPS  = S_DIV0 + SD_STEPS;
  localparam int unsigned S_DVD    = S_STEPS + 1;
  localparam int unsigned S_ADIV0  = S_DVD + 1;
  localparam int unsigned S_TRI    = S_ADIV0 + AL_STEPS;
  localparam int unsigned S_DS     = S_TRI + 1;
  localparam int unsigned S_P      = S_DS + 1;
  localparam int unsigned S_RN     = S_P + 1;
  localparam int unsigned S_XDIV0  = S_RN + 1;
  localparam int unsigned S_UV     = S_XDIV0 + XQ_STEPS;
  localparam int unsigned S_UVMUL  = S_UV + 1;
  localparam int unsigned S_PSUM   = S_UVMUL + 1;
  localparam int unsigned S_PRE    = S_PSUM + 1;
  localparam int unsigned S_YSQ0   = S_PRE + 1;
  localparam int unsigned S_OUT    = S_YSQ0 + RY_STEPS;
  localparam int unsigned NSTAGE   = S_OUT + 1;

  typedef struct packed {
    logic [23:0]       ux;
    logic [23:0]       uy;
    logic [23:0]       ur;
    logic [47:0]       xsq;
    logic [47:0]       rsq;
    logic [47:0]       ysq;
    logic [1:0][63:0]  rad;
    logic [1:0][33:0]  srem;
    logic [1:0][31:0]  sroot;
    logic [1:0][66:0]  num;
    logic [1:0]        sat;
    logic [1:0][15:0]  q;
    logic [1:0][15:0]  steps;
    logic [1:0][31:0]  mp;
    logic [1:0][34:0]  dvd;
    logic [1:0][15:0]  drem;
    logic [1:0][34:0]  aq;
    logic              degen;
    logic              neg;
    logic [34:0]       d;
    logic [35:0]       s;
    logic [40:0]       plo;
    logic [40:0]       phi;
    logic [46:0]       asq;
    logic [58:0]       big;
    logic [59:0]       rn;
    logic              rxneg;
    logic [35:0]       xq;
    logic [23:0]       rxo;
    logic [35:0]       u;
    logic [35:0]       v;
    logic              usat;
    logic              ysat;
    logic [45:0]       rad2;
    logic [24:0]       yrem;
    logic [22:0]       yroot;
    logic [23:0]       fx;
    logic [23:0]       fy;
    logic [1:0]        status;
  } pipe_t;

endpackage

// ===== hw/rtl/two_cord_plotter_kinematics.sv =====
// ----------------------------------------------------------------------------
// two_cord_plotter_kinematics
// Inverse kinematics of a hanging two-cord plotter: step counts and the point
// reached from the quantized cord lengths.
// ----------------------------------------------------------------------------
// The block takes one target point per cycle while its skid entry is empty and
// returns one result per point, in order, through 158 pipeline stages and the
// output register. The depth is set by the chain of one-bit-per-stage units: the
// 32-step cord length root, the 16-step count division, the 35-step length
// division by steps_per_rev, the 36-step division by twice the frame width and
// the 23-step root for reached_y. The whole pipeline advances together; a skid
// register behind the output register lets one more result land while the
// sink stalls. Write configuration only while no request is in flight.
module two_cord_plotter_kinematics import tcpk_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // target_x [23:0], target_y [47:24]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // left_steps [15:0], right_steps [31:16], reached_x [55:32], reached_y [79:56]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // status [1:0]
  output logic [OUT_USER_W-1:0] m_axis_tuser,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [22:0]           cfg_data_i
);

  logic [22:0] width_q;
  logic [15:0] radius_q;
  logic [15:0] spr_q;
  logic [42:0] den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 23'd256000;
      radius_q <= 16'd2560;
      spr_q    <= 16'd200;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:   width_q  <= cfg_data_i;
        REG_SPOOL_RADIUS:  radius_q <= cfg_data_i[15:0];
        REG_STEPS_PER_REV: spr_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // length per step denominator, follows the radius register
  always_ff @(posedge clk_i) begin
    den_q <= TWO_PI_Q24 * radius_q;
  end

  function automatic pipe_t stage_step(input int unsigned k, input pipe_t i,
                                       input logic [22:0] w, input logic [15:0] r,
                                       input logic [15:0] n, input logic [42:0] den);
    pipe_t        o;
    logic [48:0]  s49;
    logic [35:0]  r2a;
    logic [35:0]  tra;
    logic [35:0]  t36;
    logic [47:0]  a48;
    logic [66:0]  num67;
    logic [66:0]  dsh;
    logic [15:0]  st16;
    logic [31:0]  mp32;
    logic [58:0]  m59;
    logic [59:0]  m60;
    logic [16:0]  rem17;
    logic [16:0]  t17;
    logic [35:0]  w36;
    logic [35:0]  al36;
    logic [35:0]  ar36;
    logic [45:0]  ww46;
    logic [58:0]  a59;
    logic [59:0]  xsh;
    logic [35:0]  axm;
    logic [35:0]  nq36;
    logic [26:0]  r2b;
    logic [26:0]  trb;
    logic [26:0]  t27;
    logic         rnd;
    logic [22:0]  y23;
    logic [23:0]  ry;
    int unsigned  sh;
    o = i;
    if (k == S_SQ) begin
      o.xsq = i.ux * i.ux;
      o.rsq = i.ur * i.ur;
      o.ysq = i.uy * i.uy;
    end else if (k == S_RAD) begin
      s49 = {1'b0, i.xsq} + {1'b0, i.ysq};
      o.rad[0] = {1'b0, s49, 14'd0};
      s49 = {1'b0, i.rsq} + {1'b0, i.ysq};
      o.rad[1] = {1'b0, s49, 14'd0};
      o.srem  = '0;
      o.sroot = '0;
    end else if (k >= S_SQRT0 && k < S_SQRT0 + LX_STEPS) begin
      for (int c = 0; c < 2; c++) begin
        r2a = {i.srem[c], i.rad[c][63:62]};
        tra = {2'b00, i.sroot[c], 2'b01};
        if (r2a >= tra) begin
          t36 = r2a - tra;
          o.srem[c]  = t36[33:0];
          o.sroot[c] = {i.sroot[c][30:0], 1'b1};
        end else begin
          o.srem[c]  = r2a[33:0];
          o.sroot[c] = {i.sroot[c][30:0], 1'b0};
        end
        o.rad[c] = {i.rad[c][61:0], 2'b00};
      end
    end else if (k == S_MUL_N) begin
      for (int c = 0; c < 2; c++) begin
        a48 = i.sroot[c] * n;
        o.num[c] = {19'd0, a48};
      end
    end else if (k == S_NUM) begin
      for (int c = 0; c < 2; c++) begin
        num67 = {1'b0, i.num[c][47:0], 18'd0} + {24'd0, den};
        o.num[c] = num67;
        o.sat[c] = num67 >= {7'd0, den, 17'd0};
      end
      o.q = '0;
    end else if (k >= S_DIV0 && k < S_DIV0 + SD_STEPS) begin
      sh  = S_DIV0 + SD_STEPS - 1 - k;
      dsh = {23'd0, den, 1'b0} << sh;
      for (int c = 0; c < 2; c++) begin
        if (i.num[c] >= dsh) begin
          o.num[c] = i.num[c] - dsh;
          o.q[c]   = {i.q[c][14:0], 1'b1};
        end else begin
          o.q[c]   = {i.q[c][14:0], 1'b0};
        end
      end
    end else if (k == S_STEPS) begin
      for (int c = 0; c < 2; c++) begin
        st16 = i.sat[c] ? STEP_MAX : i.q[c];
        mp32 = st16 * r;
        o.steps[c] = st16;
        o.mp[c]    = mp32;
      end
    end else if (k == S_DVD) begin
      for (int c = 0; c < 2; c++) begin
        m59 = i.mp[c] * TWO_PI_Q24;
        m60 = {1'b0, m59} + {21'd0, n, 23'd0};
        o.dvd[c] = m60[58:24];
      end
      o.drem = '0;
      o.aq   = '0;
    end else if (k >= S_ADIV0 && k < S_ADIV0 + AL_STEPS) begin
      for (int c = 0; c < 2; c++) begin
        rem17 = {i.drem[c], i.dvd[c][34]};
        if (rem17 >= {1'b0, n}) begin
          t17 = rem17 - {1'b0, n};
          o.drem[c] = t17[15:0];
          o.aq[c]   = {i.aq[c][33:0], 1'b1};
        end else begin
          o.drem[c] = rem17[15:0];
          o.aq[c]   = {i.aq[c][33:0], 1'b0};
        end
        o.dvd[c] = {i.dvd[c][33:0], 1'b0};
      end
    end else if (k == S_TRI) begin
      w36  = {13'd0, w};
      al36 = {1'b0, i.aq[0]};
      ar36 = {1'b0, i.aq[1]};
      o.degen = (i.aq[0] == '0) || (w == '0) || (ar36 > w36 + al36) ||
                (al36 > w36 + ar36) || (w36 > al36 + ar36);
      o.d   = (i.aq[0] >= i.aq[1]) ? i.aq[0] - i.aq[1] : i.aq[1] - i.aq[0];
      o.s   = al36 + ar36;
      o.neg = i.aq[0] < i.aq[1];
    end else if (k == S_DS) begin
      o.plo = i.d[22:0] * i.s[17:0];
      o.phi = i.d[22:0] * i.s[35:18];
      ww46  = w * w;
      o.asq = {1'b0, ww46} + {24'd0, w};
    end else if (k == S_P || k == S_PSUM) begin
      o.big = {18'd0, i.plo} + {i.phi, 18'd0};
    end else if (k == S_RN) begin
      a59 = {12'd0, i.asq};
      if (!i.neg) begin
        o.rn    = {1'b0, a59} + {1'b0, i.big};
        o.rxneg = 1'b0;
      end else if (a59 >= i.big) begin
        o.rn    = {1'b0, a59 - i.big};
        o.rxneg = 1'b0;
      end else begin
        // floor of a negative quotient: divide the magnitude rounded up
        o.rn    = {1'b0, i.big - a59} + {36'd0, w, 1'b0} - 60'd1;
        o.rxneg = 1'b1;
      end
      o.xq = '0;
    end else if (k >= S_XDIV0 && k < S_XDIV0 + XQ_STEPS) begin
      sh  = S_XDIV0 + XQ_STEPS - 1 - k;
      xsh = {36'd0, w, 1'b0} << sh;
      if (i.rn >= xsh) begin
        o.rn = i.rn - xsh;
        o.xq = {i.xq[34:0], 1'b1};
      end else begin
        o.xq = {i.xq[34:0], 1'b0};
      end
    end else if (k == S_UV) begin
      al36 = {1'b0, i.aq[0]};
      axm  = (i.xq > al36) ? al36 : i.xq;
      o.u  = al36 - axm;
      o.v  = al36 + axm;
      nq36 = 36'd0 - i.xq;
      if (!i.rxneg) begin
        o.rxo = (i.xq > {12'd0, COORD_MAX}) ? COORD_MAX : i.xq[23:0];
      end else begin
        o.rxo = (i.xq > {12'd0, COORD_MIN}) ? COORD_MIN : nq36[23:0];
      end
    end else if (k == S_UVMUL) begin
      o.usat = |i.u[35:23];
      o.plo  = i.u[22:0] * i.v[17:0];
      o.phi  = i.u[22:0] * i.v[35:18];
    end else if (k == S_PRE) begin
      o.ysat  = i.usat || (i.big >= PSAT);
      o.rad2  = i.big[45:0];
      o.yrem  = '0;
      o.yroot = '0;
    end else if (k >= S_YSQ0 && k < S_YSQ0 + RY_STEPS) begin
      r2b = {i.yrem, i.rad2[45:44]};
      trb = {2'b00, i.yroot, 2'b01};
      if (r2b >= trb) begin
        t27 = r2b - trb;
        o.yrem  = t27[24:0];
        o.yroot = {i.yroot[21:0], 1'b1};
      end else begin
        o.yrem  = r2b[24:0];
        o.yroot = {i.yroot[21:0], 1'b0};
      end
      o.rad2 = {i.rad2[43:0], 2'b00};
    end else if (k == S_OUT) begin
      // round half up: bump when the remainder exceeds the root
      rnd = i.yrem > {2'b00, i.yroot};
      y23 = i.yroot + {22'd0, rnd};
      ry  = i.ysat ? COORD_MAX : {1'b0, y23};
      if (r == '0 || n == '0) begin
        o.steps  = '0;
        o.fx     = '0;
        o.fy     = '0;
        o.status = ST_DEGEN;
      end else if (i.degen) begin
        o.fx     = '0;
        o.fy     = '0;
        o.status = ST_DEGEN;
      end else begin
        o.fx     = i.rxo;
        o.fy     = ry;
        o.status = (|i.sat) ? ST_SAT : ST_OK;
      end
    end
    return o;
  endfunction

  // input stage: cord offsets as magnitudes
  logic signed [23:0] tx;
  logic [23:0]        tx_u;
  logic [23:0]        ty_u;
  logic signed [24:0] dx_r;
  pipe_t              in_item;

  always_comb begin
    tx_u = s_axis_tdata[23:0];
    ty_u = s_axis_tdata[47:24];
    tx   = $signed(tx_u);
    dx_r = $signed({tx[23], tx}) - $signed({2'b00, width_q});
    in_item    = '0;
    in_item.ux = tx_u[23] ? 24'd0 - tx_u : tx_u;
    in_item.uy = ty_u[23] ? 24'd0 - ty_u : ty_u;
    in_item.ur = dx_r[24] ? 24'd0 - dx_r[23:0] : dx_r[23:0];
  end

  logic              en;
  logic [NSTAGE-1:0] vld_q;
  pipe_t             pipe_q [NSTAGE];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTAGE-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pipe_q[0] <= in_item;
    end
  end

  for (genvar g = 1; g < NSTAGE; g++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en) begin
        pipe_q[g] <= stage_step(g, pipe_q[g-1], width_q, radius_q, spr_q, den_q);
      end
    end
  end

  // output register with one skid entry
  localparam int unsigned WORD_W = OUT_USER_W + OUT_DATA_W;

  logic [WORD_W-1:0] inc_word;
  logic              inc_vld;
  logic              out_load;
  logic              out_v_q, out_v_d;
  logic              skid_v_q, skid_v_d;
  logic [WORD_W-1:0] out_q;
  logic [WORD_W-1:0] skid_q;

  assign inc_word = {pipe_q[NSTAGE-1].status, pipe_q[NSTAGE-1].fy, pipe_q[NSTAGE-1].fx,
                     pipe_q[NSTAGE-1].steps[1], pipe_q[NSTAGE-1].steps[0]};
  assign inc_vld  = vld_q[NSTAGE-1];
  assign en       = !skid_v_q;
  assign out_load = !out_v_q || m_axis_tready;

  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    if (out_load) begin
      out_v_d  = skid_v_q || inc_vld;
      skid_v_d = 1'b0;
    end else if (en && inc_vld) begin
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= skid_v_q ? skid_q : inc_word;
    end else if (en) begin
      skid_q <= inc_word;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q[OUT_DATA_W-1:0];
  assign m_axis_tuser  = out_q[WORD_W-1:OUT_DATA_W];

endmodule

// ===== hw/rtl/tcpk_checker.sv =====
// ----------------------------------------------------------------------------
// tcpk_checker
// Port-level checks on the results of the plotter kinematics block.
// ----------------------------------------------------------------------------
module tcpk_checker import tcpk_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [OUT_USER_W-1:0] m_axis_tuser
);

  // only the three status codes ever leave the block
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_DEGEN ||
                       m_axis_tuser == ST_SAT))
    else $error("unknown status code");

  // a degenerate result carries no reached point
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ST_DEGEN) |-> (m_axis_tdata[79:32] == '0))
    else $error("degenerate result with nonzero point");

  // reached_y is never negative
  a_y_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[79])
    else $error("negative reached_y");

  // saturation status means one count sits at its ceiling
  a_sat_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ST_SAT) |->
      (m_axis_tdata[15:0] == STEP_MAX || m_axis_tdata[31:16] == STEP_MAX))
    else $error("saturation flagged without a saturated count");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind two_cord_plotter_kinematics tcpk_checker u_tcpk_checker (.*);

// ===== dv/two_cord_plotter_kinematics_tb.sv =====
// ----------------------------------------------------------------------------
// two_cord_plotter_kinematics_tb
// Streams target points through the kinematics pipeline and checks every
// result field against an in-bench predictor, over several register settings
// and with random stalls on both the request and the result side.
// ----------------------------------------------------------------------------
module two_cord_plotter_kinematics_tb;
  import tcpk_pkg::*;

  typedef struct {
    logic [15:0] left_steps;
    logic [15:0] right_steps;
    logic [23:0] reached_x;
    logic [23:0] reached_y;
    logic [1:0]  status;
  } point_res_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  cfg_we_i;
  logic [1:0]            cfg_idx_i;
  logic [22:0]           cfg_data_i;

  // testbench copy of the registers
  bit [63:0] width_q;
  bit [63:0] radius_q;
  bit [63:0] nsteps_q;

  point_res_t reached_q[$];
  int         fail_cnt;
  int         point_cnt;
  int         result_cnt;
  int         sat_cnt;
  int         degen_cnt;
  bit         idle_en;

  two_cord_plotter_kinematics i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic bit [63:0] int_root(bit [63:0] n);
    bit [63:0] r;
    bit [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit [63:0] abs_val(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic bit [63:0] step_count(bit [63:0] sq, bit [63:0] den, ref bit sat);
    bit [63:0] lx;
    bit [63:0] a;
    bit [63:0] lim;
    lx  = int_root(sq << 14);
    a   = lx * nsteps_q;
    lim = (64'd131071 * den + (64'd1 << 18) - 1) >> 18;
    if (a >= lim) begin
      sat = 1'b1;
      return 64'(STEP_MAX);
    end
    return ((a << 18) + den) / (2 * den);
  endfunction

  function automatic point_res_t predict_point(logic [23:0] x, logic [23:0] y);
    point_res_t res;
    longint     tx;
    longint     ty;
    longint     rx;
    longint     ry;
    longint     q;
    longint     rm;
    longint     a;
    bit [63:0]  w;
    bit [63:0]  den;
    bit [63:0]  sl;
    bit [63:0]  sr;
    bit [63:0]  al;
    bit [63:0]  ar;
    bit [63:0]  tw;
    bit [63:0]  d;
    bit [63:0]  s;
    bit [63:0]  plo;
    bit [63:0]  axm;
    bit [63:0]  u;
    bit [63:0]  v;
    bit [63:0]  p;
    bit [63:0]  rt;
    bit [63:0]  psat;
    bit         sat;
    tx  = longint'(signed'(x));
    ty  = longint'(signed'(y));
    w   = width_q;
    rx  = 0;
    ry  = 0;
    sat = 1'b0;
    if (radius_q == 0 || nsteps_q == 0) begin
      res = '{16'd0, 16'd0, 24'd0, 24'd0, ST_DEGEN};
      return res;
    end
    den = 64'(TWO_PI_Q24) * radius_q;
    sl  = step_count(abs_val(tx) * abs_val(tx) + abs_val(ty) * abs_val(ty), den, sat);
    sr  = step_count(abs_val(tx - longint'(w)) * abs_val(tx - longint'(w))
                     + abs_val(ty) * abs_val(ty), den, sat);
    al  = (sl * den + (nsteps_q << 23)) / (nsteps_q << 24);
    ar  = (sr * den + (nsteps_q << 23)) / (nsteps_q << 24);
    if (al == 0 || w == 0 || ar > w + al || al > w + ar || w > al + ar) begin
      res.status = ST_DEGEN;
    end else begin
      tw   = 2 * w;
      d    = (al > ar) ? al - ar : ar - al;
      s    = al + ar;
      plo  = d * (s % tw);
      q    = longint'(d * (s / tw) + plo / tw);
      rm   = longint'(plo % tw);
      a    = longint'(w * w + w);
      psat = 64'(PSAT);
      if (al >= ar) rx = (a + rm) / longint'(tw) + q;
      else          rx = (a - rm) / longint'(tw) - q;
      axm = abs_val(rx);
      if (axm > al) axm = al;
      u = al - axm;
      v = al + axm;
      if (u != 0 && v >= (psat + u - 1) / u) begin
        ry = 64'h7F_FFFF;
      end else begin
        p  = u * v;
        rt = int_root(p);
        if (p - rt * rt > rt) rt++;
        ry = longint'(rt);
      end
      if (rx > 64'sd8388607)  rx = 64'sd8388607;
      if (rx < -64'sd8388608) rx = -64'sd8388608;
      if (ry > 64'sd8388607)  ry = 64'sd8388607;
      res.status = sat ? ST_SAT : ST_OK;
    end
    res.left_steps  = sl[15:0];
    res.right_steps = sr[15:0];
    res.reached_x   = rx[23:0];
    res.reached_y   = ry[23:0];
    return res;
  endfunction

  // check each result against the oldest prediction
  always @(posedge clk_i) begin
    point_res_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (reached_q.size() == 0) begin
        $display("%0t: unexpected result data=%h user=%h", $time, m_axis_tdata, m_axis_tuser);
        fail_cnt++;
      end else begin
        exp_r = reached_q.pop_front();
        result_cnt++;
        if (exp_r.status == ST_SAT) sat_cnt++;
        if (exp_r.status == ST_DEGEN) degen_cnt++;
        if (m_axis_tdata[15:0] !== exp_r.left_steps) begin
          $display("%0t: left_steps expected %0d actual %0d", $time,
                   exp_r.left_steps, m_axis_tdata[15:0]);
          fail_cnt++;
        end
        if (m_axis_tdata[31:16] !== exp_r.right_steps) begin
          $display("%0t: right_steps expected %0d actual %0d", $time,
                   exp_r.right_steps, m_axis_tdata[31:16]);
          fail_cnt++;
        end
        if (m_axis_tdata[55:32] !== exp_r.reached_x) begin
          $display("%0t: reached_x expected %h actual %h", $time,
                   exp_r.reached_x, m_axis_tdata[55:32]);
          fail_cnt++;
        end
        if (m_axis_tdata[79:56] !== exp_r.reached_y) begin
          $display("%0t: reached_y expected %h actual %h", $time,
                   exp_r.reached_y, m_axis_tdata[79:56]);
          fail_cnt++;
        end
        if (m_axis_tuser !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, m_axis_tuser);
          fail_cnt++;
        end
      end
    end
  end

  // result side back pressure
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_en && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // call at a rising edge; returns at the edge that took the request
  task automatic send_point(logic [23:0] x, logic [23:0] y);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    reached_q.push_back(predict_point(x, y));
    point_cnt++;
  endtask

  task automatic drain_pipe();
    s_axis_tvalid <= 1'b0;
    while (reached_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [22:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == REG_FRAME_WIDTH)        width_q  = 64'(val);
    else if (idx == REG_SPOOL_RADIUS)  radius_q = 64'(val[15:0]);
    else if (idx == REG_STEPS_PER_REV) nsteps_q = 64'(val[15:0]);
  endtask

  task automatic set_geometry(logic [22:0] w, logic [15:0] r, logic [15:0] n);
    drain_pipe();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_SPOOL_RADIUS, {7'd0, r});
    write_reg(REG_STEPS_PER_REV, {7'd0, n});
  endtask

  task automatic test_directed_points();
    logic [23:0] w;
    w = width_q[23:0];
    send_point(24'd0, 24'd0);               // left length zero
    send_point(w, 24'd0);                   // right motor
    send_point(w >> 1, 24'd51200);
    send_point(24'h7F_FFFF, 24'h7F_FFFF);   // saturates both counts
    send_point(24'h80_0000, 24'h80_0000);
    send_point(24'h80_0000, 24'h7F_FFFF);
    send_point(24'h7F_FFFF, 24'h80_0000);
    send_point(24'hFF_FFFF, 24'hFF_FFFF);
    send_point(24'd1, 24'd1);
    send_point(w + 24'd25600, 24'd25600);   // right of the frame
    send_point(w >> 2, -24'sd25600);        // above the motors
    send_point(24'd128, 24'd0);             // half a millimetre from the left motor
    send_point(w >> 1, 24'd0);              // flat triangle
    send_point(24'h55_5555, 24'h2A_AAAA);
    send_point(24'h2A_AAAA, 24'h55_5555);
  endtask

  task automatic test_special_registers();
    set_geometry(23'd256000, 16'd0, 16'd200);  // zero radius
    send_point(24'd1000, 24'd2000);
    set_geometry(23'd256000, 16'd2560, 16'd0); // zero step count
    send_point(24'd1000, 24'd2000);
    set_geometry(23'd0, 16'd2560, 16'd200);    // zero frame width
    send_point(24'd1000, 24'd2000);
    drain_pipe();
    write_reg(2'd3, 23'h7F_FFFF);              // unused index, ignored
    set_geometry(23'd256000, 16'd2560, 16'd200);
    send_point(24'd128000, 24'd128000);
  endtask

  task automatic test_random_points(int count);
    logic [23:0] x;
    logic [23:0] y;
    int          span;
    span = (width_q > 64'd4000000) ? 4000000 : int'(width_q);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        x = 24'($urandom());
        y = 24'($urandom());
      end else begin
        // inside the frame, where the triangle closes
        x = 24'($urandom_range(0, span));
        y = 24'($urandom_range(1, span + 1));
      end
      send_point(x, y);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_FRAME_WIDTH;
    cfg_data_i    = '0;
    width_q       = 64'd256000;
    radius_q      = 64'd2560;
    nsteps_q      = 64'd200;
    fail_cnt      = 0;
    point_cnt     = 0;
    result_cnt    = 0;
    sat_cnt       = 0;
    degen_cnt     = 0;
    idle_en       = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_points();
    test_special_registers();
    test_random_points(100);
    set_geometry(23'd1, 16'd1, 16'd1);
    test_directed_points();
    test_random_points(100);
    set_geometry(23'h7F_FFFF, 16'hFFFF, 16'hFFFF);
    test_directed_points();
    test_random_points(100);
    set_geometry(23'd1000, 16'd1, 16'hFFFF);
    test_random_points(100);
    set_geometry(23'($urandom_range(1000, 8388607)), 16'($urandom_range(1, 65535)),
                 16'($urandom_range(1, 65535)));
    test_random_points(100);
    set_geometry(23'($urandom_range(25600, 1000000)), 16'($urandom_range(256, 8000)),
                 16'($urandom_range(50, 3200)));
    test_random_points(100);
    // closing stretch at full rate on both sides
    set_geometry(23'd256000, 16'd2560, 16'd200);
    idle_en = 1'b0;
    test_random_points(150);

    drain_pipe();
    $display("Sent %0d points over default, corner and random geometries; checked %0d results",
             point_cnt, result_cnt);
    $display("Results with saturated counts: %0d, degenerate: %0d", sat_cnt, degen_cnt);
    if (fail_cnt == 0) begin
      $display("** two_cord_plotter_kinematics: PASSED **");
    end else begin
      $display("** two_cord_plotter_kinematics: FAILED **");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Timeout with %0d results outstanding", reached_q.size());
    $display("** two_cord_plotter_kinematics: FAILED **");
    $finish;
  end

endmodule
